@@ sv/linear_stereo_resampler_top_assert.svh @@
`ifndef LINEAR_STEREO_RESAMPLER_TOP_ASSERT_SVH
`define LINEAR_STEREO_RESAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lsr_pkg.sv @@
`default_nettype none

package lsr_pkg;

  localparam int unsigned FRAME_COUNT_BITS_DEF = 20;
  localparam int unsigned FRAC_BITS_DEF        = 16;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned TDATA_W     = 2 * SAMPLE_W;
  localparam int unsigned STEP_W      = 21;
  localparam int unsigned STEP_FRAC   = 16;
  localparam int unsigned OUT_LIMIT_W = 20;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 21;

  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [STEP_W-1:0]      STEP_RESET      = 21'd65536;
  localparam logic [OUT_LIMIT_W-1:0] OUT_LIMIT_RESET = 20'hFFFFF;

  localparam int unsigned         SAT_POS_MAG = 32767;
  localparam int unsigned         SAT_NEG_MAG = 32768;
  localparam logic [SAMPLE_W-1:0] SAT_MAX     = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAT_MIN     = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP      = 2'd0,
    CFG_OUT_LIMIT = 2'd1
  } lsr_cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MULT,
    ST_ROUND,
    ST_EMIT,
    ST_FINISH
  } lsr_state_e;

  typedef struct packed {
    logic accept;
    logic calc;
    logic mult;
    logic rnd;
    logic load;
    logic finish;
  } lsr_cmd_t;

  typedef struct packed {
    logic cond;
    logic out_free;
  } lsr_sts_t;

endpackage

`default_nettype wire

@@ sv/lsr_ctrl.sv @@
`default_nettype none
`include "linear_stereo_resampler_top_assert.svh"

module lsr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire lsr_pkg::lsr_sts_t sts_i,
  output lsr_pkg::lsr_cmd_t     cmd_o
);
  import lsr_pkg::*;

  lsr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.cond ? ST_MULT : ST_FINISH;
      end
      ST_MULT:  state_d = ST_ROUND;
      ST_ROUND: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.cond ? ST_CHECK : ST_FINISH;
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_CHECK:  cmd_o.calc   = 1'b1;
      ST_MULT:   cmd_o.mult   = 1'b1;
      ST_ROUND:  cmd_o.rnd    = 1'b1;
      ST_EMIT:   cmd_o.load   = sts_i.out_free;
      ST_FINISH: cmd_o.finish = 1'b1;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  `LSR_ASSERT_IMPL(a_load_needs_room, cmd_o.load, sts_i.out_free, "result loaded over a full output")
  `LSR_ASSERT_NEXT(a_accept_to_check, cmd_o.accept, state_q == ST_CHECK, "accepted frame not checked")
  `LSR_ASSERT_NEXT(a_emit_holds, (state_q == ST_EMIT) && !sts_i.out_free, state_q == ST_EMIT, "result dropped while output stalled")

endmodule

`default_nettype wire

@@ sv/lsr_datapath.sv @@
`default_nettype none

module lsr_datapath #(
  parameter int unsigned FRAME_COUNT_BITS = lsr_pkg::FRAME_COUNT_BITS_DEF,
  parameter int unsigned FRAC_BITS        = lsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [lsr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lsr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic [lsr_pkg::TDATA_W-1:0]      in_data_i,
  input  wire logic                             in_last_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [lsr_pkg::TDATA_W-1:0]           out_data_o,
  output logic                                  out_last_o,
  input  wire lsr_pkg::lsr_cmd_t                cmd_i,
  output lsr_pkg::lsr_sts_t                     sts_o
);
  import lsr_pkg::*;

  localparam int unsigned POS_W   = FRAME_COUNT_BITS + FRAC_BITS + 1;
  localparam int unsigned FRAC_W  = FRAC_BITS + 1;
  localparam int unsigned ESTEP_W = STEP_W + FRAC_BITS - STEP_FRAC;
  localparam int unsigned DIFF_W  = SAMPLE_W + 1;
  localparam int unsigned PROD_W  = DIFF_W + FRAC_W + 1;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned QUO_W   = SUM_W - FRAC_BITS;

  logic [STEP_W-1:0]      step_q;
  logic [OUT_LIMIT_W-1:0] out_limit_q;

  logic [POS_W-1:0]            pos_q;
  logic [FRAME_COUNT_BITS-1:0] seen_q;
  logic [OUT_LIMIT_W-1:0]      emitted_q;
  logic [RES_CNT_W-1:0]        n_q;
  logic signed [SAMPLE_W-1:0]  prev_l_q, prev_r_q;
  logic                        out_valid_q;

  logic signed [SAMPLE_W-1:0] cur_l_q, cur_r_q;
  logic                       end_q;
  logic [FRAC_W-1:0]          frac_q;
  logic signed [DIFF_W-1:0]   diff_l_q, diff_r_q;
  logic signed [PROD_W-1:0]   prod_l_q, prod_r_q;
  logic [SAMPLE_W-1:0]        res_l_q, res_r_q;
  logic [SAMPLE_W-1:0]        out_l_q, out_r_q;
  logic                       out_last_q;

  logic [STEP_W+FRAC_BITS-1:0] step_ext;
  logic [ESTEP_W-1:0]          step_s;
  logic [ESTEP_W-1:0]          step_min;
  logic [ESTEP_W-1:0]          step_eff;
  logic [FRAME_COUNT_BITS:0]   span;
  logic [POS_W-1:0]            limit_w;
  logic [POS_W-1:0]            base_w;
  logic [FRAME_COUNT_BITS-1:0] seen_dec;
  logic [FRAC_W-1:0]           frac_w;
  logic signed [FRAC_W:0]      frac_s;
  logic signed [PROD_W-1:0]    prod_l_w, prod_r_w;
  logic signed [SUM_W-1:0]     sum_l_w, sum_r_w;
  logic                        cond_w;

  function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0]    mag;
    logic [SUM_W-1:0]    rnd;
    logic [QUO_W-1:0]    q;
    logic [SAMPLE_W-1:0] res;
    mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    rnd = mag + (SUM_W'(1) << (FRAC_BITS - 1));
    q   = rnd[SUM_W-1:FRAC_BITS];
    if (v[SUM_W-1]) begin
      if (q > QUO_W'(SAT_NEG_MAG)) res = SAT_MIN;
      else res = SAMPLE_W'(QUO_W'(0) - q);
    end else begin
      if (q > QUO_W'(SAT_POS_MAG)) res = SAT_MAX;
      else res = SAMPLE_W'(q);
    end
    return res;
  endfunction

  assign step_ext = {step_q, {FRAC_BITS{1'b0}}};
  assign step_s   = step_ext[STEP_W+FRAC_BITS-1:STEP_FRAC];
  assign step_min = ESTEP_W'(1) << (FRAC_BITS - 4);
  assign step_eff = (step_s < step_min) ? step_min : step_s;

  assign span     = (FRAME_COUNT_BITS+1)'(seen_q) + (FRAME_COUNT_BITS+1)'(end_q);
  assign limit_w  = {span, {FRAC_BITS{1'b0}}};
  assign seen_dec = seen_q - FRAME_COUNT_BITS'(1);
  assign base_w   = {1'b0, seen_dec, {FRAC_BITS{1'b0}}};
  assign frac_w   = (pos_q >= base_w) ? FRAC_W'(pos_q - base_w) : '0;

  assign cond_w = (seen_q != '0) && (n_q < RES_CNT_W'(MAX_RESULTS))
                  && (emitted_q < out_limit_q) && (pos_q < limit_w);

  assign frac_s   = {1'b0, frac_q};
  assign prod_l_w = diff_l_q * frac_s;
  assign prod_r_w = diff_r_q * frac_s;
  assign sum_l_w  = (SUM_W'(prev_l_q) <<< FRAC_BITS) + SUM_W'(prod_l_q);
  assign sum_r_w  = (SUM_W'(prev_r_q) <<< FRAC_BITS) + SUM_W'(prod_r_q);

  assign sts_o.cond     = cond_w;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_RESET;
      out_limit_q <= OUT_LIMIT_RESET;
      pos_q       <= '0;
      seen_q      <= '0;
      emitted_q   <= '0;
      n_q         <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_STEP:      step_q      <= cfg_data_i[STEP_W-1:0];
          CFG_OUT_LIMIT: out_limit_q <= cfg_data_i[OUT_LIMIT_W-1:0];
          default:       step_q      <= step_q;
        endcase
      end
      if (cmd_i.accept) n_q <= '0;
      if (cmd_i.mult) begin
        pos_q     <= pos_q + POS_W'(step_eff);
        emitted_q <= emitted_q + OUT_LIMIT_W'(1);
        n_q       <= n_q + RES_CNT_W'(1);
      end
      if (cmd_i.finish) begin
        prev_l_q <= cur_l_q;
        prev_r_q <= cur_r_q;
        if (end_q) begin
          pos_q     <= '0;
          seen_q    <= '0;
          emitted_q <= '0;
        end else if (seen_q != '1) begin
          seen_q <= seen_q + FRAME_COUNT_BITS'(1);
        end
      end
      if (cmd_i.load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_l_q <= in_data_i[SAMPLE_W-1:0];
      cur_r_q <= in_data_i[TDATA_W-1:SAMPLE_W];
      end_q   <= in_last_i;
    end
    if (cmd_i.calc) begin
      frac_q   <= frac_w;
      diff_l_q <= DIFF_W'(cur_l_q) - DIFF_W'(prev_l_q);
      diff_r_q <= DIFF_W'(cur_r_q) - DIFF_W'(prev_r_q);
    end
    if (cmd_i.mult) begin
      prod_l_q <= prod_l_w;
      prod_r_q <= prod_r_w;
    end
    if (cmd_i.rnd) begin
      res_l_q <= round_sat(sum_l_w);
      res_r_q <= round_sat(sum_r_w);
    end
    if (cmd_i.load) begin
      out_l_q    <= res_l_q;
      out_r_q    <= res_r_q;
      out_last_q <= !cond_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_r_q, out_l_q};
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

@@ sv/linear_stereo_resampler_top.sv @@
// Each frame is taken in the idle state; a frame with no result then passes the
// check and finish steps, and each result passes the check, multiply, round and
// load steps of the shared interpolation datapath, the last one followed by finish.
// A result waits in the load step until the master side has taken the last one.
// A waiting result blocks: no new frame is taken until it is loaded into the output register.
// Reset (rst_ni low, asynchronous): step 1.0, output limit 0xFFFFF (its maximum), block
// state and previous frame cleared to zero, output register empty.
`default_nettype none

module linear_stereo_resampler_top #(
  parameter int unsigned FRAME_COUNT_BITS = lsr_pkg::FRAME_COUNT_BITS_DEF,
  parameter int unsigned FRAC_BITS        = lsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // left_in [15:0], right_in [31:16]
  input  wire logic [lsr_pkg::TDATA_W-1:0]    s_axis_tdata,
  input  wire logic                           s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // left_out [15:0], right_out [31:16]
  output logic [lsr_pkg::TDATA_W-1:0]         m_axis_tdata,
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lsr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lsr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lsr_pkg::*;

  lsr_cmd_t cmd;
  lsr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsr_datapath #(
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS),
    .FRAC_BITS        (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire
